### design/spieth_pkg.sv
package spieth_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int MAX_RESULTS  = 5;
    localparam int POS_W        = 11;
    localparam int LEN_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;

    localparam logic [POS_W-1:0] POS_LIMIT   = 11'd2047;
    localparam logic [POS_W-1:0] POS_MAGIC0  = 11'd0;
    localparam logic [POS_W-1:0] POS_MAGIC1  = 11'd1;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 11'd4;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 11'd5;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [7:0]       MAGIC_RESET   = 8'hA0;
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 11'd128;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 11'd1518;

    localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd2;

    localparam logic [2:0] KIND_FRAME   = 3'd0;
    localparam logic [2:0] KIND_CRC     = 3'd1;
    localparam logic [2:0] KIND_MAGIC   = 3'd2;
    localparam logic [2:0] KIND_OVERLEN = 3'd3;
    localparam logic [2:0] KIND_TRUNC   = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic       last;
    } result_t;

    // reflected crc-32, one byte, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        logic [7:0]  d;
        logic        fb;
        c = crc_in;
        d = b;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ d[0];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

### design/spi_frame_to_ethernet_framer.sv
// spi_frame_to_ethernet_framer
// input channel (in_valid/in_ready): one byte of an spi transfer per request,
//   with start_of_transfer and end_of_transfer marks
// output channel (out_valid/out_ready): frame bytes, crc bytes (low byte
//   first) and status results (bad magic, overlength, truncated), frame_end
//   set on the last result of a frame or status
// config channel (cfg_valid/cfg_ready): cfg_index 0 magic byte, 1 minimum
//   frame length, 2 maximum payload length; always ready, write only when idle
// results: the results of a byte are registered and appear in the cycle after it is accepted
// flow: one byte per cycle while each byte gives at most one result and
//   out_ready is high; a byte that gives k results holds the output until all k
//   are taken (k up to 5 on the last frame byte, which carries the four crc
//   bytes), and the next byte is taken in the cycle its last result is taken
// reset: registers return to magic 0xA0, minimum 128, maximum 1518, no
//   results pending, parsing starts at byte 0 of a transfer
// stall: while out_ready is low the pending results hold and in_ready drops
module spi_frame_to_ethernet_framer
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [7:0]                             spi_byte,
    input  logic                                   start_of_transfer,
    input  logic                                   end_of_transfer,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [7:0]                             out_byte,
    output logic [2:0]                             out_kind,
    output logic                                   frame_end,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [spieth_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spieth_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(spieth_pkg::MAX_RESULTS);
    localparam int CNT_W = $clog2(spieth_pkg::MAX_RESULTS + 1);
    localparam logic [11:0] HDR = 12'(spieth_pkg::HEADER_BYTES);

    logic [7:0]                    magic_reg;
    logic [spieth_pkg::LEN_W-1:0]  min_len_reg;
    logic [spieth_pkg::LEN_W-1:0]  max_len_reg;

    logic [spieth_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]                    len_hi_reg, len_hi_next;
    logic [spieth_pkg::LEN_W-1:0]  frame_len_reg, frame_len_next;
    logic [31:0]                   crc_reg, crc_next;
    logic                          drop_reg, drop_next;

    spieth_pkg::result_t           bundle_reg [spieth_pkg::MAX_RESULTS];
    spieth_pkg::result_t           slots [spieth_pkg::MAX_RESULTS];
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              idx_reg;
    logic [CNT_W-1:0]              n;

    logic                          in_accept;
    logic                          last_pending;
    logic [spieth_pkg::POS_W-1:0]  p;
    logic [15:0]                   len;
    logic [11:0]                   end_pos;
    logic [31:0]                   crc_new;
    logic [31:0]                   crc_out;
    logic                          done;

    assign cfg_ready    = 1'b1;
    assign out_valid    = (idx_reg != cnt_reg);
    assign last_pending = ((idx_reg + CNT_W'(1)) == cnt_reg);
    assign in_ready     = !out_valid || (last_pending && out_ready);
    assign in_accept    = in_valid && in_ready;

    assign out_byte  = bundle_reg[idx_reg[IDX_W-1:0]].data;
    assign out_kind  = bundle_reg[idx_reg[IDX_W-1:0]].kind;
    assign frame_end = bundle_reg[idx_reg[IDX_W-1:0]].last;

    assign len     = {len_hi_reg, spi_byte};
    assign end_pos = HDR + {1'b0, frame_len_reg} - 12'd1;
    assign crc_new = spieth_pkg::crc_byte(crc_reg, spi_byte);
    assign crc_out = ~crc_new;

    always_comb
    begin
        for (int i = 0; i < spieth_pkg::MAX_RESULTS; i++)
        begin
            slots[i] = '0;
        end
        n              = '0;
        done           = 1'b0;
        crc_next       = crc_reg;
        frame_len_next = frame_len_reg;
        len_hi_next    = len_hi_reg;
        drop_next      = drop_reg;
        p              = pos_reg;

        // restart mid-frame
        if (start_of_transfer)
        begin
            if (!drop_reg && (pos_reg > spieth_pkg::POS_LEN_LO))
            begin
                slots[n[IDX_W-1:0]] = '{8'd0, spieth_pkg::KIND_TRUNC, 1'b1};
                n = n + CNT_W'(1);
            end
            p         = '0;
            drop_next = 1'b0;
        end

        if (!drop_next && (p != spieth_pkg::POS_LIMIT))
        begin
            if (p == spieth_pkg::POS_MAGIC0)
            begin
                crc_next       = spieth_pkg::CRC_INIT;
                frame_len_next = '0;
                if (spi_byte != magic_reg)
                begin
                    drop_next = 1'b1;
                end
            end
            else if (p == spieth_pkg::POS_MAGIC1)
            begin
                if (spi_byte != magic_reg)
                begin
                    drop_next = 1'b1;
                    slots[n[IDX_W-1:0]] = '{8'd0, spieth_pkg::KIND_MAGIC, 1'b1};
                    n = n + CNT_W'(1);
                end
            end
            else if (p == spieth_pkg::POS_LEN_HI)
            begin
                len_hi_next = spi_byte;
            end
            else if (p == spieth_pkg::POS_LEN_LO)
            begin
                if (len > {5'd0, max_len_reg})
                begin
                    drop_next = 1'b1;
                    slots[n[IDX_W-1:0]] = '{8'd0, spieth_pkg::KIND_OVERLEN, 1'b1};
                    n = n + CNT_W'(1);
                end
                else if (len == 16'd0)
                begin
                    drop_next = 1'b1;
                end
                else if (len[10:0] < min_len_reg)
                begin
                    frame_len_next = min_len_reg;
                end
                else
                begin
                    frame_len_next = len[10:0];
                end
            end
            else if (({1'b0, p} >= HDR) && ({1'b0, p} <= end_pos) && (frame_len_reg != '0))
            begin
                crc_next = crc_new;
                slots[n[IDX_W-1:0]] = '{spi_byte, spieth_pkg::KIND_FRAME, 1'b0};
                n = n + CNT_W'(1);
                if ({1'b0, p} == end_pos)
                begin
                    slots[n[IDX_W-1:0]] = '{crc_out[7:0], spieth_pkg::KIND_CRC, 1'b0};
                    n = n + CNT_W'(1);
                    slots[n[IDX_W-1:0]] = '{crc_out[15:8], spieth_pkg::KIND_CRC, 1'b0};
                    n = n + CNT_W'(1);
                    slots[n[IDX_W-1:0]] = '{crc_out[23:16], spieth_pkg::KIND_CRC, 1'b0};
                    n = n + CNT_W'(1);
                    slots[n[IDX_W-1:0]] = '{crc_out[31:24], spieth_pkg::KIND_CRC, 1'b1};
                    n = n + CNT_W'(1);
                    drop_next = 1'b1;
                    done      = 1'b1;
                end
            end
        end

        pos_next = (p != spieth_pkg::POS_LIMIT) ? (p + 11'd1) : p;

        // short transfer
        if (end_of_transfer)
        begin
            if (!drop_next && !done && (p >= spieth_pkg::POS_LEN_LO))
            begin
                slots[n[IDX_W-1:0]] = '{8'd0, spieth_pkg::KIND_TRUNC, 1'b1};
                n = n + CNT_W'(1);
            end
            drop_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg     <= spieth_pkg::MAGIC_RESET;
            min_len_reg   <= spieth_pkg::MIN_LEN_RESET;
            max_len_reg   <= spieth_pkg::MAX_LEN_RESET;
            pos_reg       <= '0;
            len_hi_reg    <= '0;
            frame_len_reg <= '0;
            crc_reg       <= spieth_pkg::CRC_INIT;
            drop_reg      <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    spieth_pkg::REG_MAGIC:   magic_reg   <= cfg_data[7:0];
                    spieth_pkg::REG_MIN_LEN: min_len_reg <= cfg_data;
                    spieth_pkg::REG_MAX_LEN: max_len_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_accept)
            begin
                pos_reg       <= pos_next;
                len_hi_reg    <= len_hi_next;
                frame_len_reg <= frame_len_next;
                crc_reg       <= crc_next;
                drop_reg      <= drop_next;
                cnt_reg       <= n;
                idx_reg       <= '0;
            end
            else if (out_valid && out_ready)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    // result bundle, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < spieth_pkg::MAX_RESULTS; i++)
            begin
                bundle_reg[i] <= slots[i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_pending) |-> !in_ready)
        else $error("input taken while several results pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= CNT_W'(spieth_pkg::MAX_RESULTS)) && (idx_reg <= cnt_reg))
        else $error("result index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((out_kind == spieth_pkg::KIND_MAGIC) ||
                       (out_kind == spieth_pkg::KIND_OVERLEN) ||
                       (out_kind == spieth_pkg::KIND_TRUNC))) |-> (frame_end && out_byte == 8'd0))
        else $error("status result without frame end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && start_of_transfer) |=> (pos_reg == 11'd1))
        else $error("start of transfer did not restart position");
`endif

endmodule
